// ===== rtl/core/rvbb_pkg.sv =====
// Shared types, constants and the sine table of the rotated vertex bounding box unit.
package rvbb_pkg;

    localparam int COORD_W   = 24;
    localparam int COEF_FRAC = 14;
    localparam int COEF_W    = COEF_FRAC + 2;
    localparam int ANGLE_W   = 9;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = COORD_W + COEF_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int SHR_W     = SUM_W - COEF_FRAC;
    localparam int MCOEF_W   = 2 * COEF_W + 2;
    localparam int MSHR_W    = MCOEF_W - COEF_FRAC;
    localparam int STEP_W    = 5;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [PROD_W-1:0]  t_prod;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_Z = 2'd2;

    localparam t_coef COEF_ONE  = t_coef'(1 << COEF_FRAC);
    localparam t_coef COEF_MONE = t_coef'(-(1 << COEF_FRAC));
    localparam t_coef COEF_ZERO = '0;

    localparam t_coord COORD_MAX = t_coord'((1 << (COORD_W - 1)) - 1);
    localparam t_coord COORD_MIN = t_coord'(-(1 << (COORD_W - 1)));

    localparam logic [STEP_W-1:0] STEP_HALF = 5'd9;
    localparam logic [STEP_W-1:0] STEP_LAST = 5'd17;

    typedef enum logic [1:0] {
        BUILD_IDLE,
        BUILD_TRIG,
        BUILD_PROD
    } t_build_state;

    typedef struct packed {
        logic busy;
        logic trig_load;
        logic prod_en;
    } t_build_ctrl;

    localparam logic [14:0] QUARTER_SINE [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
        15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
        15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
        15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
        15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
        15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
        15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
        15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
        15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
        15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
        15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
    };

    function automatic t_coef sine_coef(input logic [ANGLE_W:0] deg);
        logic [ANGLE_W:0] d;
        logic [ANGLE_W:0] r;
        logic [1:0]       q;
        logic [6:0]       idx;
        t_coef            v;
        d = (deg >= 10'd360) ? (deg - 10'd360) : deg;
        priority if (d >= 10'd270) begin
            q = 2'd3;
            r = d - 10'd270;
        end else if (d >= 10'd180) begin
            q = 2'd2;
            r = d - 10'd180;
        end else if (d >= 10'd90) begin
            q = 2'd1;
            r = d - 10'd90;
        end else begin
            q = 2'd0;
            r = d;
        end
        idx = q[0] ? 7'(10'd90 - r) : r[6:0];
        v = t_coef'({1'b0, QUARTER_SINE[idx]});
        if (q[1]) begin
            v = -v;
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/rotated_vertex_bounding_box_unit.sv =====
// Rotated vertex bounding box unit: rotates a vertex stream and tracks its min/max box.
//
// Input channel: i_valid / o_stall carry one vertex per transfer (i_first_vertex,
// i_vertex_x/y/z, signed Q16.8). Output channel: o_valid / i_stall carry the box
// after that vertex (o_box_min_*, o_box_max_*). One box comes out for every vertex.
// Input transfers pass through the four-register pipeline: input register, nine 24x16
// products, rounded and saturated sums, box compare into the output register. It takes
// one vertex per cycle while neither i_stall nor a matrix rebuild holds it.
// A stalled output holds its box; the pipeline keeps taking vertices until every
// stage is full, and o_stall rises then, as it also does during a matrix rebuild.
// Configuration: i_cfg_wr_en with i_cfg_index 0/1/2 writes the x/y/z angle in whole
// degrees. Each write rebuilds the rotation matrix: a sine lookup, then the entries of
// X*Y and of that product times Z one per step, with o_stall high throughout.
// Reset (i_rst_n low, synchronous) sets the angles to zero, the matrix to identity,
// the box to all zero and empties the pipeline.
module rotated_vertex_bounding_box_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_first_vertex,
    input  logic signed [rvbb_pkg::COORD_W-1:0]  i_vertex_x,
    input  logic signed [rvbb_pkg::COORD_W-1:0]  i_vertex_y,
    input  logic signed [rvbb_pkg::COORD_W-1:0]  i_vertex_z,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [rvbb_pkg::COORD_W-1:0]  o_box_min_x,
    output logic signed [rvbb_pkg::COORD_W-1:0]  o_box_min_y,
    output logic signed [rvbb_pkg::COORD_W-1:0]  o_box_min_z,
    output logic signed [rvbb_pkg::COORD_W-1:0]  o_box_max_x,
    output logic signed [rvbb_pkg::COORD_W-1:0]  o_box_max_y,
    output logic signed [rvbb_pkg::COORD_W-1:0]  o_box_max_z,
    input  logic                                 i_cfg_wr_en,
    input  logic [rvbb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rvbb_pkg::ANGLE_W-1:0]         i_cfg_data
);

    logic [rvbb_pkg::ANGLE_W-1:0] r_angle_x;
    logic [rvbb_pkg::ANGLE_W-1:0] r_angle_y;
    logic [rvbb_pkg::ANGLE_W-1:0] r_angle_z;

    rvbb_pkg::t_build_state r_state;
    rvbb_pkg::t_build_state n_state;
    rvbb_pkg::t_build_ctrl  ctrl;
    logic [rvbb_pkg::STEP_W-1:0] r_step;
    logic                        cfg_hit;

    rvbb_pkg::t_coef r_sx, r_cx, r_sy, r_cy, r_sz, r_cz;
    rvbb_pkg::t_coef mx [9];
    rvbb_pkg::t_coef my [9];
    rvbb_pkg::t_coef mz [9];
    rvbb_pkg::t_coef r_t [9];
    rvbb_pkg::t_coef r_coef [9];
    rvbb_pkg::t_coef m_a [9];
    rvbb_pkg::t_coef m_b [9];
    rvbb_pkg::t_coef op_a [3];
    rvbb_pkg::t_coef op_b [3];
    logic [3:0] ent;
    logic [1:0] row;
    logic [1:0] col;
    logic signed [rvbb_pkg::MCOEF_W-1:0] m_sum;
    logic signed [rvbb_pkg::MSHR_W-1:0]  m_shr;
    rvbb_pkg::t_coef                     m_ent;

    logic                   r_v1, r_v2, r_v3, r_ov;
    logic                   r_f1, r_f2, r_f3;
    rvbb_pkg::t_coord       r_vin [3];
    rvbb_pkg::t_prod        r_p [9];
    rvbb_pkg::t_coord       r_rot [3];
    rvbb_pkg::t_coord       r_lo [3];
    rvbb_pkg::t_coord       r_hi [3];
    logic                   out_rdy, s3_rdy, s2_rdy, s1_rdy, in_xfer;
    logic signed [rvbb_pkg::SUM_W-1:0] c_sum [3];
    logic signed [rvbb_pkg::SHR_W-1:0] c_shr [3];
    rvbb_pkg::t_coord       c_rot [3];

    // configuration and matrix build sequencer
    assign cfg_hit = i_cfg_wr_en && (i_cfg_index == rvbb_pkg::CFG_ANGLE_X ||
                                     i_cfg_index == rvbb_pkg::CFG_ANGLE_Y ||
                                     i_cfg_index == rvbb_pkg::CFG_ANGLE_Z);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rvbb_pkg::BUILD_IDLE: begin
                if (cfg_hit) n_state = rvbb_pkg::BUILD_TRIG;
            end
            rvbb_pkg::BUILD_TRIG: begin
                n_state = rvbb_pkg::BUILD_PROD;
                if (cfg_hit) n_state = rvbb_pkg::BUILD_TRIG;
            end
            rvbb_pkg::BUILD_PROD: begin
                priority if (cfg_hit) n_state = rvbb_pkg::BUILD_TRIG;
                else if (r_step == rvbb_pkg::STEP_LAST) n_state = rvbb_pkg::BUILD_IDLE;
                else n_state = rvbb_pkg::BUILD_PROD;
            end
            default: n_state = rvbb_pkg::BUILD_IDLE;
        endcase
    end

    always_comb begin
        ctrl.busy      = (r_state != rvbb_pkg::BUILD_IDLE);
        ctrl.trig_load = (r_state == rvbb_pkg::BUILD_TRIG);
        ctrl.prod_en   = (r_state == rvbb_pkg::BUILD_PROD) && !cfg_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rvbb_pkg::BUILD_IDLE;
            r_step    <= '0;
            r_angle_x <= '0;
            r_angle_y <= '0;
            r_angle_z <= '0;
        end else begin
            r_state <= n_state;
            if (ctrl.trig_load) r_step <= '0;
            else if (ctrl.prod_en) r_step <= r_step + 5'd1;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    rvbb_pkg::CFG_ANGLE_X: r_angle_x <= i_cfg_data;
                    rvbb_pkg::CFG_ANGLE_Y: r_angle_y <= i_cfg_data;
                    rvbb_pkg::CFG_ANGLE_Z: r_angle_z <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.trig_load) begin
            r_sx <= rvbb_pkg::sine_coef({1'b0, r_angle_x});
            r_cx <= rvbb_pkg::sine_coef({1'b0, r_angle_x} + 10'd90);
            r_sy <= rvbb_pkg::sine_coef({1'b0, r_angle_y});
            r_cy <= rvbb_pkg::sine_coef({1'b0, r_angle_y} + 10'd90);
            r_sz <= rvbb_pkg::sine_coef({1'b0, r_angle_z});
            r_cz <= rvbb_pkg::sine_coef({1'b0, r_angle_z} + 10'd90);
        end
    end

    always_comb begin
        mx = '{rvbb_pkg::COEF_ONE, rvbb_pkg::COEF_ZERO, rvbb_pkg::COEF_ZERO,
               rvbb_pkg::COEF_ZERO, r_cx, r_sx,
               rvbb_pkg::COEF_ZERO, -r_sx, r_cx};
        my = '{r_cy, rvbb_pkg::COEF_ZERO, -r_sy,
               rvbb_pkg::COEF_ZERO, rvbb_pkg::COEF_ONE, rvbb_pkg::COEF_ZERO,
               r_sy, rvbb_pkg::COEF_ZERO, r_cy};
        mz = '{r_cz, r_sz, rvbb_pkg::COEF_ZERO,
               -r_sz, r_cz, rvbb_pkg::COEF_ZERO,
               rvbb_pkg::COEF_ZERO, rvbb_pkg::COEF_ZERO, rvbb_pkg::COEF_ONE};
    end

    // one product entry per cycle unless an angle write restarts the build: X*Y into r_t, then r_t*Z into r_coef
    always_comb begin
        ent = (r_step < rvbb_pkg::STEP_HALF) ? r_step[3:0]
                                              : 4'(r_step - rvbb_pkg::STEP_HALF);
        priority if (ent >= 4'd6) begin
            row = 2'd2;
            col = 2'(ent - 4'd6);
        end else if (ent >= 4'd3) begin
            row = 2'd1;
            col = 2'(ent - 4'd3);
        end else begin
            row = 2'd0;
            col = ent[1:0];
        end
        for (int n = 0; n < 9; n++) begin
            m_a[n] = (r_step < rvbb_pkg::STEP_HALF) ? mx[n] : r_t[n];
            m_b[n] = (r_step < rvbb_pkg::STEP_HALF) ? my[n] : mz[n];
        end
        for (int k = 0; k < 3; k++) begin
            unique case (row)
                2'd0:    op_a[k] = m_a[k];
                2'd1:    op_a[k] = m_a[3 + k];
                default: op_a[k] = m_a[6 + k];
            endcase
            unique case (col)
                2'd0:    op_b[k] = m_b[3 * k];
                2'd1:    op_b[k] = m_b[3 * k + 1];
                default: op_b[k] = m_b[3 * k + 2];
            endcase
        end
        m_sum = rvbb_pkg::MCOEF_W'(op_a[0]) * rvbb_pkg::MCOEF_W'(op_b[0])
              + rvbb_pkg::MCOEF_W'(op_a[1]) * rvbb_pkg::MCOEF_W'(op_b[1])
              + rvbb_pkg::MCOEF_W'(op_a[2]) * rvbb_pkg::MCOEF_W'(op_b[2])
              + (rvbb_pkg::MCOEF_W'(1) <<< (rvbb_pkg::COEF_FRAC - 1));
        m_shr = rvbb_pkg::MSHR_W'(m_sum >>> rvbb_pkg::COEF_FRAC);
        priority if (m_shr > rvbb_pkg::MSHR_W'(rvbb_pkg::COEF_ONE)) begin
            m_ent = rvbb_pkg::COEF_ONE;
        end else if (m_shr < rvbb_pkg::MSHR_W'(rvbb_pkg::COEF_MONE)) begin
            m_ent = rvbb_pkg::COEF_MONE;
        end else begin
            m_ent = rvbb_pkg::COEF_W'(m_shr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.prod_en && r_step < rvbb_pkg::STEP_HALF) begin
            r_t[ent] <= m_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < 9; n++) begin
                r_coef[n] <= (n % 4 == 0) ? rvbb_pkg::COEF_ONE : rvbb_pkg::COEF_ZERO;
            end
        end else if (ctrl.prod_en && r_step >= rvbb_pkg::STEP_HALF) begin
            r_coef[ent] <= m_ent;
        end
    end

    // vertex pipeline
    assign out_rdy = !r_ov || !i_stall;
    assign s3_rdy  = !r_v3 || out_rdy;
    assign s2_rdy  = !r_v2 || s3_rdy;
    assign s1_rdy  = !r_v1 || s2_rdy;
    assign o_stall = !s1_rdy || ctrl.busy;
    assign in_xfer = i_valid && !o_stall;
    assign o_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (s1_rdy) r_v1 <= in_xfer;
            if (s2_rdy) r_v2 <= r_v1;
            if (s3_rdy) r_v3 <= r_v2;
            if (out_rdy) r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_f1     <= i_first_vertex;
            r_vin[0] <= i_vertex_x;
            r_vin[1] <= i_vertex_y;
            r_vin[2] <= i_vertex_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_rdy && r_v1) begin
            r_f2 <= r_f1;
            for (int n = 0; n < 9; n++) begin
                r_p[n] <= rvbb_pkg::PROD_W'(r_vin[n / 3]) * rvbb_pkg::PROD_W'(r_coef[n]);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            c_sum[j] = rvbb_pkg::SUM_W'(r_p[j]) + rvbb_pkg::SUM_W'(r_p[3 + j])
                     + rvbb_pkg::SUM_W'(r_p[6 + j])
                     + (rvbb_pkg::SUM_W'(1) <<< (rvbb_pkg::COEF_FRAC - 1));
            c_shr[j] = rvbb_pkg::SHR_W'(c_sum[j] >>> rvbb_pkg::COEF_FRAC);
            priority if (c_shr[j] > rvbb_pkg::SHR_W'(rvbb_pkg::COORD_MAX)) begin
                c_rot[j] = rvbb_pkg::COORD_MAX;
            end else if (c_shr[j] < rvbb_pkg::SHR_W'(rvbb_pkg::COORD_MIN)) begin
                c_rot[j] = rvbb_pkg::COORD_MIN;
            end else begin
                c_rot[j] = rvbb_pkg::COORD_W'(c_shr[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_rdy && r_v2) begin
            r_f3  <= r_f2;
            r_rot <= c_rot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 3; j++) begin
                r_lo[j] <= '0;
                r_hi[j] <= '0;
            end
        end else if (out_rdy && r_v3) begin
            for (int j = 0; j < 3; j++) begin
                if (r_f3 || r_rot[j] < r_lo[j]) r_lo[j] <= r_rot[j];
                if (r_f3 || r_rot[j] > r_hi[j]) r_hi[j] <= r_rot[j];
            end
        end
    end

    assign o_box_min_x = r_lo[0];
    assign o_box_min_y = r_lo[1];
    assign o_box_min_z = r_lo[2];
    assign o_box_max_x = r_hi[0];
    assign o_box_max_y = r_hi[1];
    assign o_box_max_z = r_hi[2];

endmodule
